[rtl/bmiv_pkg.sv]
// Shared types, constants and codes of the box mean unit.
`timescale 1ns / 1ps

package bmiv_pkg;

   // Storage sizes.
   localparam int VOLUME_DEPTH = 32768;
   localparam int VOL_AW       = $clog2(VOLUME_DEPTH);
   localparam int BOX_MAX      = 64;
   localparam int BOX_AW       = $clog2(BOX_MAX);

   // Field widths.
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 15;
   localparam int WORD_W   = 32;
   localparam int DIM_W    = 11;
   localparam int COORD_W  = 10;
   localparam int OFF_W    = 11;
   localparam int LEN_W    = 10;
   localparam int CNT_W    = 7;
   localparam int FEAT_W   = 48;
   localparam int STATUS_W = 2;

   // Datapath widths.
   localparam int POS_W   = 13;
   localparam int MUL_W   = 22;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DXY_W   = 22;
   localparam int VXY_W   = 20;
   localparam int VOL_W   = 30;
   localparam int ZT_W    = 33;
   localparam int YT_W    = 22;
   localparam int ADDR_W  = 35;
   localparam int SUM_W   = 36;
   localparam int FRAC_W  = 16;
   localparam int DIVN_W  = 51;
   localparam int REM_W   = VOL_W + 1;
   localparam int MEAN_W  = DIVN_W + 1;
   localparam int DIFF_W  = MEAN_W + 1;
   localparam int DCNT_W  = $clog2(DIVN_W);
   localparam int BOXE_W  = 3 * OFF_W + 3 * LEN_W;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // Input function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_VOLUME = 2'd0,
      FUNC_BOX    = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_ZERO  = 2'd2
   } status_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_DIM_X     = 3'd0,
      REG_DIM_Y     = 3'd1,
      REG_DIM_Z     = 3'd2,
      REG_MRI_MODE  = 3'd3,
      REG_BOX_COUNT = 3'd4
   } csr_reg_type;

   // Operand selection of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_DXY = 3'd0,
      MUL_VXY = 3'd1,
      MUL_VOL = 3'd2,
      MUL_ZS  = 3'd3,
      MUL_ZF  = 3'd4,
      MUL_YS  = 3'd5,
      MUL_YF  = 3'd6
   } mul_sel_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BOX_RD,
      ST_GEOM_POS,
      ST_GEOM_LEN,
      ST_MUL,
      ST_CORNER_ADDR,
      ST_CORNER_ACC,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              box_rd;
      logic [BOX_AW-1:0] box_addr;
      logic              geom_pos;
      logic              geom_len;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              corner_rd;
      logic [2:0]        corner;
      logic              acc_clear;
      logic              acc_en;
      logic              div_init;
      logic              div_step;
      logic              hold_first;
      logic              emit;
      logic              emit_err;
      logic [BOX_AW-1:0] num;
      logic              last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic target_bad;
      logic vol_zero;
   } dp_status_type;

endpackage

[rtl/bmiv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bmiv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bmiv_ctrl.sv]
// Controller that sequences boxes, corners and division steps of a query.
`timescale 1ns / 1ps

module bmiv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    query_accept,
   input  logic                    mri_mode,
   input  logic [bmiv_pkg::CNT_W-1:0] box_count,
   input  bmiv_pkg::dp_status_type dp_status,
   output bmiv_pkg::cmd_type       cmd,
   output logic                    busy
);
   import bmiv_pkg::*;

   state_type           state_ff, state_in;
   logic [BOX_AW-1:0]   s_ff, s_in;
   logic                phase_ff, phase_in;
   logic [2:0]          mcnt_ff, mcnt_in;
   logic [2:0]          ccnt_ff, ccnt_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]    n_used;
   logic [CNT_W-1:0]    res;
   logic                is_last;

   // Boxes in use, limited to the table, and results per query.
   always_comb begin
      if (box_count == '0) begin
         n_used = CNT_W'(1);
      end else if (box_count > CNT_W'(BOX_MAX)) begin
         n_used = CNT_W'(BOX_MAX);
      end else begin
         n_used = box_count;
      end
      res     = mri_mode ? (n_used >> 1) : n_used;
      is_last = (CNT_W'(s_ff) + CNT_W'(1)) == res;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (dp_status.target_bad || res == '0) state_in = ST_IDLE;
            else state_in = ST_BOX_RD;
         end
         ST_BOX_RD:   state_in = ST_GEOM_POS;
         ST_GEOM_POS: state_in = ST_GEOM_LEN;
         ST_GEOM_LEN: state_in = ST_MUL;
         ST_MUL: begin
            if (mcnt_ff == 3'd5) begin
               state_in = dp_status.vol_zero ? ST_FINISH : ST_CORNER_ADDR;
            end
         end
         ST_CORNER_ADDR: state_in = ST_CORNER_ACC;
         ST_CORNER_ACC: begin
            state_in = (ccnt_ff == 3'd7) ? ST_DIV_INIT : ST_CORNER_ADDR;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == DCNT_W'(DIVN_W - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if ((mri_mode && !phase_ff) || !is_last) state_in = ST_BOX_RD;
            else state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters.
   always_comb begin
      s_in     = s_ff;
      phase_in = phase_ff;
      mcnt_in  = mcnt_ff;
      ccnt_in  = ccnt_ff;
      dcnt_in  = dcnt_ff;
      case (state_ff)
         ST_CHECK: begin
            s_in     = '0;
            phase_in = 1'b0;
         end
         ST_GEOM_LEN:    mcnt_in = '0;
         ST_MUL: begin
            mcnt_in = mcnt_ff + 3'd1;
            ccnt_in = '0;
         end
         ST_CORNER_ACC:  ccnt_in = ccnt_ff + 3'd1;
         ST_DIV_INIT:    dcnt_in = '0;
         ST_DIV:         dcnt_in = dcnt_ff + DCNT_W'(1);
         ST_FINISH: begin
            if (mri_mode && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               s_in     = s_ff + BOX_AW'(1);
            end
         end
         default: ;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_DXY;
      cmd.box_addr = phase_ff ? (s_ff + BOX_AW'(res)) : s_ff;
      cmd.corner   = ccnt_ff;
      cmd.num      = s_ff;
      cmd.last     = is_last;
      case (state_ff)
         ST_CHECK: begin
            cmd.emit_err = dp_status.target_bad;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_DXY;
         end
         ST_BOX_RD: begin
            cmd.box_rd    = 1'b1;
            cmd.acc_clear = 1'b1;
         end
         ST_GEOM_POS: cmd.geom_pos = 1'b1;
         ST_GEOM_LEN: cmd.geom_len = 1'b1;
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            case (mcnt_ff)
               3'd0:    cmd.mul_sel = MUL_VXY;
               3'd1:    cmd.mul_sel = MUL_VOL;
               3'd2:    cmd.mul_sel = MUL_ZS;
               3'd3:    cmd.mul_sel = MUL_ZF;
               3'd4:    cmd.mul_sel = MUL_YS;
               default: cmd.mul_sel = MUL_YF;
            endcase
         end
         ST_CORNER_ADDR: cmd.corner_rd = 1'b1;
         ST_CORNER_ACC:  cmd.acc_en    = 1'b1;
         ST_DIV_INIT:    cmd.div_init  = 1'b1;
         ST_DIV:         cmd.div_step  = 1'b1;
         ST_FINISH: begin
            if (mri_mode && !phase_ff) cmd.hold_first = 1'b1;
            else cmd.emit = 1'b1;
         end
         default: ;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s_ff     <= '0;
         phase_ff <= 1'b0;
         mcnt_ff  <= '0;
         ccnt_ff  <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         s_ff     <= s_in;
         phase_ff <= phase_in;
         mcnt_ff  <= mcnt_in;
         ccnt_ff  <= ccnt_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/bmiv_datapath.sv]
// Datapath: stores, box geometry, corner sums, divider and result register.
`timescale 1ns / 1ps

module bmiv_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [bmiv_pkg::FUNC_W-1:0]       req_func,
   input  logic [bmiv_pkg::INDEX_W-1:0]      req_index,
   input  logic [bmiv_pkg::WORD_W-1:0]       req_volume_value,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_x,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_y,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_z,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_x,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_y,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_z,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_x,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_y,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_z,
   input  logic [bmiv_pkg::DIM_W-1:0]        dim_x,
   input  logic [bmiv_pkg::DIM_W-1:0]        dim_y,
   input  logic [bmiv_pkg::DIM_W-1:0]        dim_z,
   input  logic                              mri_mode,
   input  bmiv_pkg::cmd_type                 cmd,
   output bmiv_pkg::dp_status_type           dp_status,
   output logic                              rsp_valid,
   output logic signed [bmiv_pkg::FEAT_W-1:0] rsp_feature,
   output logic [bmiv_pkg::BOX_AW-1:0]       rsp_box_number,
   output logic [bmiv_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last
);
   import bmiv_pkg::*;

   localparam logic signed [DIFF_W-1:0] SAT_HI =
      {{(DIFF_W - FEAT_W + 1){1'b0}}, {(FEAT_W - 1){1'b1}}};
   localparam logic signed [DIFF_W-1:0] SAT_LO =
      {{(DIFF_W - FEAT_W + 1){1'b1}}, {(FEAT_W - 1){1'b0}}};

   function automatic logic [FEAT_W-1:0] sat48(input logic signed [DIFF_W-1:0] v);
      logic [FEAT_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[FEAT_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[FEAT_W-1:0];
      else r = v[FEAT_W-1:0];
      return r;
   endfunction

   // Stores.
   logic                vol_wr, box_wr;
   logic [WORD_W-1:0]   vol_rd_data;
   logic [BOXE_W-1:0]   box_rd_data;
   logic [ADDR_W-1:0]   corner_addr;

   assign vol_wr = accept && (req_func == FUNC_VOLUME)
                   && ({1'b0, req_index} < (INDEX_W + 1)'(VOLUME_DEPTH));
   assign box_wr = accept && (req_func == FUNC_BOX)
                   && ({1'b0, req_index} < (INDEX_W + 1)'(BOX_MAX));

   bmiv_ram #(.WIDTH(WORD_W), .DEPTH(VOLUME_DEPTH)) u_volume_ram (
      .clock   (clock),
      .wr_en   (vol_wr),
      .wr_addr (req_index[VOL_AW-1:0]),
      .wr_data (req_volume_value),
      .rd_en   (cmd.corner_rd),
      .rd_addr (corner_addr[VOL_AW-1:0]),
      .rd_data (vol_rd_data)
   );

   bmiv_ram #(.WIDTH(BOXE_W), .DEPTH(BOX_MAX)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_wr),
      .wr_addr (req_index[BOX_AW-1:0]),
      .wr_data ({req_off_x, req_off_y, req_off_z, req_len_x, req_len_y, req_len_z}),
      .rd_en   (cmd.box_rd),
      .rd_addr (cmd.box_addr),
      .rd_data (box_rd_data)
   );

   // Target latched at query accept and checked against the volume.
   logic [COORD_W-1:0] tgt_ff [3];
   logic [DIM_W-1:0]   dim_v [3];

   assign dim_v[0] = dim_x;
   assign dim_v[1] = dim_y;
   assign dim_v[2] = dim_z;

   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_QUERY) begin
         tgt_ff[0] <= req_target_x;
         tgt_ff[1] <= req_target_y;
         tgt_ff[2] <= req_target_z;
      end
   end

   assign dp_status.target_bad = ({1'b0, tgt_ff[0]} >= dim_x) || ({1'b0, tgt_ff[1]} >= dim_y)
                                 || ({1'b0, tgt_ff[2]} >= dim_z);

   // Box geometry: clamp the start corner, then clip the length.
   logic signed [OFF_W-1:0] off_v [3];
   logic [LEN_W-1:0]        len_raw [3];
   logic [DIM_W-1:0]        s_ff [3], s_in [3];
   logic [DIM_W-1:0]        f_ff [3], f_in [3];
   logic [LEN_W-1:0]        len_ff [3], len_in [3];

   assign off_v[0]   = box_rd_data[BOXE_W-1 -: OFF_W];
   assign off_v[1]   = box_rd_data[BOXE_W-1-OFF_W -: OFF_W];
   assign off_v[2]   = box_rd_data[BOXE_W-1-2*OFF_W -: OFF_W];
   assign len_raw[0] = box_rd_data[3*LEN_W-1 -: LEN_W];
   assign len_raw[1] = box_rd_data[2*LEN_W-1 -: LEN_W];
   assign len_raw[2] = box_rd_data[LEN_W-1:0];

   always_comb begin
      logic signed [POS_W-1:0] pos;
      logic [DIM_W:0]          end_pos;
      for (int k = 0; k < 3; k++) begin
         s_in[k]   = s_ff[k];
         f_in[k]   = f_ff[k];
         len_in[k] = len_ff[k];
         pos       = $signed({3'b000, tgt_ff[k]}) + POS_W'(off_v[k]);
         end_pos   = {1'b0, s_ff[k]} + (DIM_W + 1)'(len_ff[k]);
         if (cmd.geom_pos) begin
            len_in[k] = len_raw[k];
            if (pos >= $signed({2'b00, dim_v[k]})) s_in[k] = dim_v[k] - DIM_W'(1);
            else if (pos < 0) s_in[k] = '0;
            else s_in[k] = pos[DIM_W-1:0];
         end
         if (cmd.geom_len) begin
            if (end_pos >= {1'b0, dim_v[k]}) begin
               len_in[k] = LEN_W'(dim_v[k] - DIM_W'(1) - s_ff[k]);
               f_in[k]   = dim_v[k] - DIM_W'(1);
            end else begin
               f_in[k] = end_pos[DIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s_ff[k]   <= s_in[k];
         f_ff[k]   <= f_in[k];
         len_ff[k] <= len_in[k];
      end
   end

   assign dp_status.vol_zero = (len_ff[0] == '0) || (len_ff[1] == '0) || (len_ff[2] == '0);

   // Shared multiplier for plane size, box volume and row terms.
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [DXY_W-1:0]  dxy_ff;
   logic [VXY_W-1:0]  vxy_ff;
   logic [VOL_W-1:0]  vol_ff;
   logic [ZT_W-1:0]   zs_ff, zf_ff;
   logic [YT_W-1:0]   ys_ff, yf_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_DXY: begin mul_a = MUL_W'(dim_x);     mul_b = MUL_W'(dim_y);     end
         MUL_VXY: begin mul_a = MUL_W'(len_ff[0]); mul_b = MUL_W'(len_ff[1]); end
         MUL_VOL: begin mul_a = MUL_W'(vxy_ff);    mul_b = MUL_W'(len_ff[2]); end
         MUL_ZS:  begin mul_a = MUL_W'(s_ff[2]);   mul_b = dxy_ff;            end
         MUL_ZF:  begin mul_a = MUL_W'(f_ff[2]);   mul_b = dxy_ff;            end
         MUL_YS:  begin mul_a = MUL_W'(s_ff[1]);   mul_b = MUL_W'(dim_x);     end
         MUL_YF:  begin mul_a = MUL_W'(f_ff[1]);   mul_b = MUL_W'(dim_x);     end
         default: begin mul_a = '0;                mul_b = '0;                end
      endcase
      prod = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_DXY: dxy_ff <= prod[DXY_W-1:0];
            MUL_VXY: vxy_ff <= prod[VXY_W-1:0];
            MUL_VOL: vol_ff <= prod[VOL_W-1:0];
            MUL_ZS:  zs_ff  <= prod[ZT_W-1:0];
            MUL_ZF:  zf_ff  <= prod[ZT_W-1:0];
            MUL_YS:  ys_ff  <= prod[YT_W-1:0];
            MUL_YF:  yf_ff  <= prod[YT_W-1:0];
            default: ;
         endcase
      end
   end

   // Corner address; a corner beyond the store reads as zero.
   logic                    cin_ff, cin_in;
   logic                    cadd_ff, cadd_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] corner_val;

   assign corner_addr = ADDR_W'(cmd.corner[2] ? zf_ff : zs_ff)
                        + ADDR_W'(cmd.corner[1] ? yf_ff : ys_ff)
                        + ADDR_W'(cmd.corner[0] ? f_ff[0] : s_ff[0]);

   always_comb begin
      cin_in     = cin_ff;
      cadd_in    = cadd_ff;
      if (cmd.corner_rd) begin
         cin_in  = corner_addr < ADDR_W'(VOLUME_DEPTH);
         cadd_in = ^cmd.corner;
      end
      corner_val = cin_ff ? $signed({{(SUM_W - WORD_W){1'b0}}, vol_rd_data}) : '0;
      acc_in     = acc_ff;
      if (cmd.acc_clear) acc_in = '0;
      else if (cmd.acc_en) acc_in = cadd_ff ? (acc_ff + corner_val) : (acc_ff - corner_val);
   end

   always_ff @(posedge clock) begin
      cin_ff  <= cin_in;
      cadd_ff <= cadd_in;
      acc_ff  <= acc_in;
   end

   // Restoring divider, one quotient bit per cycle, on magnitudes.
   logic [DIVN_W-1:0] divq_ff, divq_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;

   always_comb begin
      logic [SUM_W-1:0] mag;
      logic [REM_W:0]   trial;
      divq_in = divq_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      mag     = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
      trial   = {rem_ff, divq_ff[DIVN_W-1]};
      if (cmd.div_init) begin
         divq_in = {mag[DIVN_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
         rem_in  = '0;
         neg_in  = acc_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         if (trial >= (REM_W + 1)'(vol_ff)) begin
            rem_in  = REM_W'(trial - (REM_W + 1)'(vol_ff));
            divq_in = {divq_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[REM_W-1:0];
            divq_in = {divq_ff[DIVN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      divq_ff <= divq_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

   // Mean of the current box; the first box of a pair is held.
   logic signed [MEAN_W-1:0] mean_cur;
   logic signed [MEAN_W-1:0] mean_a_ff;
   logic                     ok_a_ff;

   assign mean_cur = neg_ff ? -$signed({1'b0, divq_ff}) : $signed({1'b0, divq_ff});

   always_ff @(posedge clock) begin
      if (cmd.hold_first) begin
         mean_a_ff <= mean_cur;
         ok_a_ff   <= !dp_status.vol_zero;
      end
   end

   // Result register.
   logic                     valid_ff, valid_in;
   logic [FEAT_W-1:0]        feat_ff, feat_in;
   logic [BOX_AW-1:0]        num_ff, num_in;
   status_type               stat_ff, stat_in;
   logic                     last_ff, last_in;
   logic                     ok_now;

   always_comb begin
      ok_now   = mri_mode ? (ok_a_ff && !dp_status.vol_zero) : !dp_status.vol_zero;
      valid_in = cmd.emit || cmd.emit_err;
      feat_in  = feat_ff;
      num_in   = num_ff;
      stat_in  = stat_ff;
      last_in  = last_ff;
      if (cmd.emit_err) begin
         feat_in = '0;
         num_in  = '0;
         stat_in = STATUS_RANGE;
         last_in = 1'b1;
      end else if (cmd.emit) begin
         num_in  = cmd.num;
         last_in = cmd.last;
         if (!ok_now) begin
            feat_in = '0;
            stat_in = STATUS_ZERO;
         end else begin
            stat_in = STATUS_OK;
            if (mri_mode) feat_in = sat48(DIFF_W'(mean_a_ff) - DIFF_W'(mean_cur));
            else feat_in = sat48(DIFF_W'(mean_cur));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      feat_ff <= feat_in;
      num_ff  <= num_in;
      stat_ff <= stat_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_feature    = feat_ff;
   assign rsp_box_number = num_ff;
   assign rsp_status     = stat_ff;
   assign rsp_last       = last_ff;

endmodule

[rtl/box_mean_from_integral_volume_unit.sv]
// Top level of the box mean unit: configuration registers, controller and datapath.
`timescale 1ns / 1ps

// Volume and box writes (func 0 and 1) never raise busy.
// A query raises busy until its last result has been shown; results appear on
// the rsp_ ports for one cycle each, marked by rsp_valid, and cannot be held
// off. A target outside the volume gives one error word from the check state.
// Otherwise each box walks a box table read, geometry in two steps, six steps
// of the shared multiplier, eight corner reads of the single volume read port,
// divider set-up, the one-bit-per-cycle divider over all 51 quotient bits,
// and a finishing step; a box of zero volume skips the reads and the divider.
// In MRI mode both boxes of every pair are walked in turn.

module box_mean_from_integral_volume_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bmiv_pkg::FUNC_W-1:0]       req_func,
   input  logic [bmiv_pkg::INDEX_W-1:0]      req_index,
   input  logic [bmiv_pkg::WORD_W-1:0]       req_volume_value,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_x,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_y,
   input  logic signed [bmiv_pkg::OFF_W-1:0] req_off_z,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_x,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_y,
   input  logic [bmiv_pkg::LEN_W-1:0]        req_len_z,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_x,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_y,
   input  logic [bmiv_pkg::COORD_W-1:0]      req_target_z,
   output logic                              rsp_valid,
   output logic signed [bmiv_pkg::FEAT_W-1:0] rsp_feature,
   output logic [bmiv_pkg::BOX_AW-1:0]       rsp_box_number,
   output logic [bmiv_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bmiv_pkg::CSR_AW-1:0]       paddr,
   input  logic [bmiv_pkg::CSR_DW-1:0]       pwdata,
   output logic [bmiv_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);
   import bmiv_pkg::*;

   // Configuration registers.
   logic [DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic             mri_ff;
   logic [CNT_W-1:0] box_count_ff;
   logic             csr_write;
   csr_reg_type      csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = csr_reg_type'(paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff     <= DIM_W'(32);
         dim_y_ff     <= DIM_W'(32);
         dim_z_ff     <= DIM_W'(32);
         mri_ff       <= 1'b0;
         box_count_ff <= CNT_W'(1);
      end else if (csr_write) begin
         case (csr_sel)
            REG_DIM_X:     dim_x_ff     <= pwdata[DIM_W-1:0];
            REG_DIM_Y:     dim_y_ff     <= pwdata[DIM_W-1:0];
            REG_DIM_Z:     dim_z_ff     <= pwdata[DIM_W-1:0];
            REG_MRI_MODE:  mri_ff       <= pwdata[0];
            REG_BOX_COUNT: box_count_ff <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_sel)
         REG_DIM_X:     prdata = CSR_DW'(dim_x_ff);
         REG_DIM_Y:     prdata = CSR_DW'(dim_y_ff);
         REG_DIM_Z:     prdata = CSR_DW'(dim_z_ff);
         REG_MRI_MODE:  prdata = CSR_DW'(mri_ff);
         REG_BOX_COUNT: prdata = CSR_DW'(box_count_ff);
         default:       prdata = '0;
      endcase
   end

   // Controller and datapath.
   logic          accept;
   logic          query_accept;
   cmd_type       cmd;
   dp_status_type dp_status;

   assign accept       = start && !busy;
   assign query_accept = accept && (req_func == FUNC_QUERY);

   bmiv_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .query_accept (query_accept),
      .mri_mode     (mri_ff),
      .box_count    (box_count_ff),
      .dp_status    (dp_status),
      .cmd          (cmd),
      .busy         (busy)
   );

   bmiv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_func         (req_func),
      .req_index        (req_index),
      .req_volume_value (req_volume_value),
      .req_off_x        (req_off_x),
      .req_off_y        (req_off_y),
      .req_off_z        (req_off_z),
      .req_len_x        (req_len_x),
      .req_len_y        (req_len_y),
      .req_len_z        (req_len_z),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_target_z     (req_target_z),
      .dim_x            (dim_x_ff),
      .dim_y            (dim_y_ff),
      .dim_z            (dim_z_ff),
      .mri_mode         (mri_ff),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_feature      (rsp_feature),
      .rsp_box_number   (rsp_box_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   // A query keeps the block busy in the next cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> busy)
      else $error("query accepted but block not busy");

   // An out-of-volume word is always the last word of its query.
   a_range_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RANGE) |-> rsp_last)
      else $error("range error word not marked last");

   // Error words carry a zero feature.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_feature == '0))
      else $error("error word with non-zero feature");

   // The last word of a query leaves the block idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after last word");

endmodule
